/* rtl/qstc_pkg.sv */
// ----------------------------------------------------------------------------
// qstc_pkg
// Shared widths, codes, word types and the square root step for the
// smallest-three quaternion codec.
// ----------------------------------------------------------------------------
package qstc_pkg;

   localparam int COMP_W      = 16;
   localparam int CODE_W      = 10;
   localparam int DROP_W      = 2;
   localparam int VAL_W       = COMP_W + 1;
   localparam int MAG_W       = 15;
   localparam int SQ_W        = 30;
   localparam int RAD_W       = 31;
   localparam int ROOT_W      = 32;
   localparam int ROOT_MAX    = 32767;

   localparam longint unsigned SQRT2_Q16 = 92682;

   localparam int NUM_LANES   = 3;
   localparam int LANE_STAGES = 4;
   localparam int SQRT_STAGES = 8;
   localparam int ST_LANE     = 1;
   localparam int ST_RAD      = ST_LANE + LANE_STAGES;
   localparam int NUM_STAGES  = ST_RAD + SQRT_STAGES + 2;

   localparam logic KIND_ENCODE = 1'b0;
   localparam logic KIND_DECODE = 1'b1;

   localparam logic [DROP_W-1:0] IDX_X = 2'd0;
   localparam logic [DROP_W-1:0] IDX_Y = 2'd1;
   localparam logic [DROP_W-1:0] IDX_Z = 2'd2;
   localparam logic [DROP_W-1:0] IDX_W = 2'd3;

   typedef struct packed {
      logic              kind;
      logic [DROP_W-1:0] dropped;
   } tag_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] val;
      logic [CODE_W-1:0]       code;
   } lane_op_type;

   typedef struct packed {
      logic [CODE_W-1:0]        code;
      logic signed [COMP_W-1:0] v;
      logic [SQ_W-1:0]          sq;
   } lane_res_type;

   typedef struct packed {
      tag_type                             tag;
      logic [NUM_LANES-1:0][COMP_W-1:0]    val;
   } side_type;

   typedef struct packed {
      logic [RAD_W-1:0]  r;
      logic [ROOT_W-1:0] s;
   } sqrt_type;

   typedef struct packed {
      logic [DROP_W-1:0]        dropped_out;
      logic [CODE_W-1:0]        code_out_a;
      logic [CODE_W-1:0]        code_out_b;
      logic [CODE_W-1:0]        code_out_c;
      logic signed [COMP_W-1:0] res_x;
      logic signed [COMP_W-1:0] res_y;
      logic signed [COMP_W-1:0] res_z;
      logic signed [COMP_W-1:0] res_w;
   } rsp_type;

   // one digit of the restoring square root
   function automatic sqrt_type sqrt_step(sqrt_type a, logic [ROOT_W-1:0] b);
      sqrt_type          o;
      logic [ROOT_W-1:0] t;
      t = a.s + b;
      if (ROOT_W'(a.r) >= t) begin
         o.r = RAD_W'(ROOT_W'(a.r) - t);
         o.s = (a.s >> 1) + b;
      end else begin
         o.r = a.r;
         o.s = a.s >> 1;
      end
      return o;
   endfunction

endpackage

/* rtl/qstc_select.sv */
// ----------------------------------------------------------------------------
// qstc_select
// Front stage: finds the largest-magnitude component, flips signs when it is
// negative and routes the three kept components and codes to the lanes.
// ----------------------------------------------------------------------------
module qstc_select import qstc_pkg::*; (
   input  logic                          clock,
   input  logic                          en,
   input  logic                          kind,
   input  logic signed [COMP_W-1:0]      comp_x,
   input  logic signed [COMP_W-1:0]      comp_y,
   input  logic signed [COMP_W-1:0]      comp_z,
   input  logic signed [COMP_W-1:0]      comp_w,
   input  logic [DROP_W-1:0]             dropped_in,
   input  logic [CODE_W-1:0]             code_in_a,
   input  logic [CODE_W-1:0]             code_in_b,
   input  logic [CODE_W-1:0]             code_in_c,
   output tag_type                       tag,
   output lane_op_type [NUM_LANES-1:0]   op
);

   logic signed [VAL_W-1:0]     ext [4];
   logic signed [VAL_W-1:0]     mag [4];
   logic signed [VAL_W-1:0]     best;
   logic [DROP_W-1:0]           big;
   logic                        flip;
   logic [DROP_W-1:0]           src [NUM_LANES];
   logic [CODE_W-1:0]           codes [NUM_LANES];
   tag_type                     tag_in, tag_ff;
   lane_op_type [NUM_LANES-1:0] op_in, op_ff;

   always_comb begin
      ext[0] = VAL_W'(comp_x);
      ext[1] = VAL_W'(comp_y);
      ext[2] = VAL_W'(comp_z);
      ext[3] = VAL_W'(comp_w);
      for (int i = 0; i < 4; i++) begin
         mag[i] = ext[i][VAL_W-1] ? -ext[i] : ext[i];
      end
      // ties keep the earlier component
      best = mag[0];
      big  = IDX_X;
      for (int i = 1; i < 4; i++) begin
         if (mag[i] > best) begin
            best = mag[i];
            big  = DROP_W'(i);
         end
      end
      flip     = ext[big][VAL_W-1];
      codes[0] = code_in_a;
      codes[1] = code_in_b;
      codes[2] = code_in_c;
      for (int j = 0; j < NUM_LANES; j++) begin
         src[j]         = (DROP_W'(j) < big) ? DROP_W'(j) : DROP_W'(j + 1);
         op_in[j].val   = flip ? -ext[src[j]] : ext[src[j]];
         op_in[j].code  = codes[j];
      end
      tag_in.kind    = kind;
      tag_in.dropped = (kind == KIND_ENCODE) ? big : dropped_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff <= tag_in;
         op_ff  <= op_in;
      end
   end

   assign tag = tag_ff;
   assign op  = op_ff;

endmodule

/* rtl/qstc_lane.sv */
// ----------------------------------------------------------------------------
// qstc_lane
// One kept component: quantizes an encode operand and dequantizes a decode
// code (reciprocal multiply plus one correction), then squares the result.
// ----------------------------------------------------------------------------
module qstc_lane import qstc_pkg::*; #(
   parameter int CODE_BITS = 10
) (
   input  logic                   clock,
   input  logic [LANE_STAGES-1:0] en,
   input  lane_op_type            op,
   output lane_res_type           res
);

   localparam longint unsigned SCALE = (64'd1 << CODE_BITS) - 64'd1;

   // quantize: floor((a*sqrt2*S + 2^31*(S+1)) / 2^32)
   localparam longint unsigned QK  = SQRT2_Q16 * SCALE;
   localparam int QKW = $clog2(QK + 1) + 1;
   localparam int PW  = VAL_W + QKW;
   localparam int NW  = PW + 1;
   localparam int HIW = NW - 32;
   localparam logic signed [QKW-1:0] QK_V  = QKW'(QK);
   localparam logic signed [NW-1:0]  OFS_V = NW'(64'd1 << (31 + CODE_BITS));

   // dequantize: round(mag * 2^31 / DEN), estimate then correct by one
   localparam longint unsigned DEN = SCALE * SQRT2_Q16;
   localparam longint unsigned D2  = 2 * DEN;
   localparam int P    = CODE_BITS + 1;
   localparam longint unsigned C1  = (64'd1 << (31 + P)) / DEN;
   localparam int C1W  = $clog2(C1 + 1);
   localparam int P1W  = CODE_BITS + C1W;
   localparam int D2W  = $clog2(D2 + 1);
   localparam int PR2W = MAG_W + D2W;
   localparam int CW   = ((CODE_BITS + 32) > PR2W ? (CODE_BITS + 32) : PR2W) + 1;
   localparam logic [C1W-1:0]      C1_V   = C1W'(C1);
   localparam logic [D2W-1:0]      D2_V   = D2W'(D2);
   localparam logic [P1W:0]        HALF_V = (P1W + 1)'(1) << (P - 1);
   localparam logic [CODE_BITS:0]  S_V    = (CODE_BITS + 1)'(SCALE);

   // stage 1
   logic [CODE_BITS-1:0]     c;
   logic [CODE_BITS:0]       twoc, mag_full;
   logic                     neg1_in, neg1_ff;
   logic [CODE_BITS-1:0]     mag1_in, mag1_ff;
   logic signed [PW-1:0]     penc_in, penc_ff;
   logic [P1W-1:0]           p1_in, p1_ff;
   // stage 2
   logic signed [NW-1:0]     numenc;
   logic [HIW-1:0]           hi;
   logic [CODE_BITS-1:0]     code2_in, code2_ff;
   logic [P1W:0]             est_sum;
   logic [MAG_W-1:0]         est2_in, est2_ff;
   logic [PR2W-1:0]          prod2_in, prod2_ff;
   logic [CODE_BITS-1:0]     mag2_ff;
   logic                     neg2_ff;
   // stage 3
   logic [CW-1:0]            lhs;
   logic [MAG_W-1:0]         q;
   logic [COMP_W-1:0]        q_ext;
   logic signed [COMP_W-1:0] v3_in, v3_ff;
   logic [CODE_BITS-1:0]     code3_ff;
   // stage 4
   logic signed [2*COMP_W-1:0] sq_full;
   logic [SQ_W-1:0]          sq4_ff;
   logic signed [COMP_W-1:0] v4_ff;
   logic [CODE_BITS-1:0]     code4_ff;

   always_comb begin
      c        = op.code[CODE_BITS-1:0];
      twoc     = {c, 1'b0};
      neg1_in  = ~c[CODE_BITS-1];
      mag_full = neg1_in ? (S_V - twoc) : (twoc - S_V);
      mag1_in  = mag_full[CODE_BITS-1:0];
      p1_in    = P1W'(mag1_in) * P1W'(C1_V);
      penc_in  = PW'(op.val) * PW'(QK_V);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         penc_ff <= penc_in;
         p1_ff   <= p1_in;
         mag1_ff <= mag1_in;
         neg1_ff <= neg1_in;
      end
   end

   always_comb begin
      numenc = NW'(penc_ff) + OFS_V;
      hi     = numenc[NW-1:32];
      priority if (numenc[NW-1]) begin
         code2_in = '0;
      end else if (hi > HIW'(SCALE)) begin
         code2_in = CODE_BITS'(SCALE);
      end else begin
         code2_in = hi[CODE_BITS-1:0];
      end
      est_sum  = (P1W + 1)'(p1_ff) + HALF_V;
      est2_in  = MAG_W'(est_sum >> P);
      prod2_in = PR2W'(est2_in + MAG_W'(1)) * PR2W'(D2_V);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         code2_ff  <= code2_in;
         est2_ff   <= est2_in;
         prod2_ff  <= prod2_in;
         mag2_ff   <= mag1_ff;
         neg2_ff   <= neg1_ff;
      end
   end

   always_comb begin
      lhs   = (CW'(mag2_ff) << 32) + CW'(DEN);
      q     = (lhs >= CW'(prod2_ff)) ? est2_ff + MAG_W'(1) : est2_ff;
      q_ext = COMP_W'(q);
      v3_in = neg2_ff ? -signed'(q_ext) : signed'(q_ext);
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         v3_ff    <= v3_in;
         code3_ff <= code2_ff;
      end
   end

   assign sq_full = v3_ff * v3_ff;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         sq4_ff   <= sq_full[SQ_W-1:0];
         v4_ff    <= v3_ff;
         code4_ff <= code3_ff;
      end
   end

   assign res.code = CODE_W'(code4_ff);
   assign res.v    = v4_ff;
   assign res.sq   = sq4_ff;

endmodule

/* rtl/qstc_sqrt.sv */
// ----------------------------------------------------------------------------
// qstc_sqrt
// Pipelined restoring integer square root, two result bits per stage.
// ----------------------------------------------------------------------------
module qstc_sqrt import qstc_pkg::*; (
   input  logic                   clock,
   input  logic [SQRT_STAGES-1:0] en,
   input  logic [RAD_W-1:0]       rad,
   output sqrt_type               res
);

   sqrt_type st_ff [SQRT_STAGES];

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
      localparam logic [ROOT_W-1:0] B_HI = ROOT_W'(1) << (30 - 4 * k);
      localparam logic [ROOT_W-1:0] B_LO = ROOT_W'(1) << (28 - 4 * k);
      sqrt_type prev, mid, nxt;

      if (k == 0) begin : g_first
         assign prev.r = rad;
         assign prev.s = '0;
      end else begin : g_next
         assign prev = st_ff[k-1];
      end

      assign mid = sqrt_step(prev, B_HI);
      assign nxt = sqrt_step(mid, B_LO);

      always_ff @(posedge clock) begin
         if (en[k]) begin
            st_ff[k] <= nxt;
         end
      end
   end

   assign res = st_ff[SQRT_STAGES-1];

endmodule

/* rtl/qstc_merge.sv */
// ----------------------------------------------------------------------------
// qstc_merge
// Combines the lanes: radicand from the three squares, square root of the
// dropped component, and assembly of the result word.
// ----------------------------------------------------------------------------
module qstc_merge import qstc_pkg::*; (
   input  logic                            clock,
   input  logic [NUM_STAGES-ST_RAD-1:0]    en,
   input  tag_type                         tag,
   input  lane_res_type [NUM_LANES-1:0]    lres,
   output rsp_type                         rsp
);

   localparam int SUM_W = SQ_W + 2;
   localparam logic [SUM_W-1:0] RAD_ONE = SUM_W'(1) << 30;

   logic [SUM_W-1:0]  sum;
   logic [RAD_W-1:0]  rad_in, rad_ff;
   side_type          side_in;
   side_type          side_ff [SQRT_STAGES+1];
   side_type          sd;
   sqrt_type          sq_out;
   logic [ROOT_W-1:0] rnd;
   logic [COMP_W-1:0] root;
   rsp_type           out_in, out_ff;

   always_comb begin
      sum    = SUM_W'(lres[0].sq) + SUM_W'(lres[1].sq) + SUM_W'(lres[2].sq);
      rad_in = (sum >= RAD_ONE) ? '0 : RAD_W'(RAD_ONE - sum);
      side_in.tag = tag;
      for (int j = 0; j < NUM_LANES; j++) begin
         side_in.val[j] = (tag.kind == KIND_ENCODE) ? COMP_W'(lres[j].code) : lres[j].v;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rad_ff     <= rad_in;
         side_ff[0] <= side_in;
      end
   end

   for (genvar k = 1; k <= SQRT_STAGES; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (en[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   qstc_sqrt u_sqrt (
      .clock (clock),
      .en    (en[SQRT_STAGES:1]),
      .rad   (rad_ff),
      .res   (sq_out)
   );

   always_comb begin
      sd   = side_ff[SQRT_STAGES];
      rnd  = (ROOT_W'(sq_out.r) > sq_out.s) ? sq_out.s + ROOT_W'(1) : sq_out.s;
      root = (rnd > ROOT_W'(ROOT_MAX)) ? COMP_W'(ROOT_MAX) : COMP_W'(rnd);
      out_in = '0;
      if (sd.tag.kind == KIND_ENCODE) begin
         out_in.dropped_out = sd.tag.dropped;
         out_in.code_out_a  = CODE_W'(sd.val[0]);
         out_in.code_out_b  = CODE_W'(sd.val[1]);
         out_in.code_out_c  = CODE_W'(sd.val[2]);
      end else begin
         unique case (sd.tag.dropped)
            IDX_X: begin
               out_in.res_x = root;
               out_in.res_y = sd.val[0];
               out_in.res_z = sd.val[1];
               out_in.res_w = sd.val[2];
            end
            IDX_Y: begin
               out_in.res_x = sd.val[0];
               out_in.res_y = root;
               out_in.res_z = sd.val[1];
               out_in.res_w = sd.val[2];
            end
            IDX_Z: begin
               out_in.res_x = sd.val[0];
               out_in.res_y = sd.val[1];
               out_in.res_z = root;
               out_in.res_w = sd.val[2];
            end
            IDX_W: begin
               out_in.res_x = sd.val[0];
               out_in.res_y = sd.val[1];
               out_in.res_z = sd.val[2];
               out_in.res_w = root;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en[SQRT_STAGES+1]) begin
         out_ff <= out_in;
      end
   end

   assign rsp = out_ff;

endmodule

/* rtl/quaternion_smallest_three_codec.sv */
// ----------------------------------------------------------------------------
// quaternion_smallest_three_codec
// Smallest-three quaternion encoder/decoder on signed Q1.15 components.
//
//   channel | direction | handshake            | word
//   req_    | in        | req_valid/req_ready  | kind, four components, code triple
//   rsp_    | out       | rsp_valid/rsp_ready  | dropped index, three codes, x y z w
//
// Fully pipelined: one word per cycle while rsp_ready is high. The path runs
// through the three-stage dequantize in each lane and the eight-stage square
// root. Under a stall (rsp_ready low) a stage holds its word only while it and
// all later stages are full, so bubbles close up; req_ready drops only when all
// 15 stages are full and rsp_ready is low. Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module quaternion_smallest_three_codec import qstc_pkg::*; #(
   parameter int CODE_BITS = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_kind,
   input  logic signed [COMP_W-1:0] req_comp_x,
   input  logic signed [COMP_W-1:0] req_comp_y,
   input  logic signed [COMP_W-1:0] req_comp_z,
   input  logic signed [COMP_W-1:0] req_comp_w,
   input  logic [DROP_W-1:0]        req_dropped_in,
   input  logic [CODE_W-1:0]        req_code_in_a,
   input  logic [CODE_W-1:0]        req_code_in_b,
   input  logic [CODE_W-1:0]        req_code_in_c,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [DROP_W-1:0]        rsp_dropped_out,
   output logic [CODE_W-1:0]        rsp_code_out_a,
   output logic [CODE_W-1:0]        rsp_code_out_b,
   output logic [CODE_W-1:0]        rsp_code_out_c,
   output logic signed [COMP_W-1:0] rsp_res_x,
   output logic signed [COMP_W-1:0] rsp_res_y,
   output logic signed [COMP_W-1:0] rsp_res_z,
   output logic signed [COMP_W-1:0] rsp_res_w
);

   localparam logic [CODE_W-1:0] SCALE = CODE_W'((1 << CODE_BITS) - 1);

   logic [NUM_STAGES-1:0]       valid_in, valid_ff;
   logic [NUM_STAGES-1:0]       rdy;
   tag_type                     tag0;
   tag_type                     tag_ff [LANE_STAGES];
   lane_op_type [NUM_LANES-1:0] op;
   lane_res_type [NUM_LANES-1:0] lres;
   rsp_type                     rsp;

   // a stage may load when rsp_ready is high or when it or any stage after it is empty
   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_rdy
      assign rdy[k] = rsp_ready | ~&valid_ff[NUM_STAGES-1:k];
   end

   always_comb begin
      valid_in[0] = rdy[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = rdy[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   qstc_select u_select (
      .clock      (clock),
      .en         (rdy[0]),
      .kind       (req_kind),
      .comp_x     (req_comp_x),
      .comp_y     (req_comp_y),
      .comp_z     (req_comp_z),
      .comp_w     (req_comp_w),
      .dropped_in (req_dropped_in),
      .code_in_a  (req_code_in_a),
      .code_in_b  (req_code_in_b),
      .code_in_c  (req_code_in_c),
      .tag        (tag0),
      .op         (op)
   );

   for (genvar k = 0; k < LANE_STAGES; k++) begin : g_tag
      always_ff @(posedge clock) begin
         if (rdy[ST_LANE+k]) begin
            tag_ff[k] <= (k == 0) ? tag0 : tag_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   for (genvar j = 0; j < NUM_LANES; j++) begin : g_lane
      qstc_lane #(
         .CODE_BITS (CODE_BITS)
      ) u_lane (
         .clock (clock),
         .en    (rdy[ST_LANE+LANE_STAGES-1:ST_LANE]),
         .op    (op[j]),
         .res   (lres[j])
      );
   end

   qstc_merge u_merge (
      .clock (clock),
      .en    (rdy[NUM_STAGES-1:ST_RAD]),
      .tag   (tag_ff[LANE_STAGES-1]),
      .lres  (lres),
      .rsp   (rsp)
   );

   assign req_ready       = rdy[0];
   assign rsp_valid       = valid_ff[NUM_STAGES-1];
   assign rsp_dropped_out = rsp.dropped_out;
   assign rsp_code_out_a  = rsp.code_out_a;
   assign rsp_code_out_b  = rsp.code_out_b;
   assign rsp_code_out_c  = rsp.code_out_c;
   assign rsp_res_x       = rsp.res_x;
   assign rsp_res_y       = rsp.res_y;
   assign rsp_res_z       = rsp.res_z;
   assign rsp_res_w       = rsp.res_w;

   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&valid_ff && !rsp_ready))
      else $error("input blocked while pipeline has room");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid_ff[0])
      else $error("accepted word missing from first stage");

   a_encode_decode_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_res_x != '0 || rsp_res_y != '0 || rsp_res_z != '0 ||
                    rsp_res_w != '0)
      |-> (rsp_dropped_out == '0 && rsp_code_out_a == '0 &&
           rsp_code_out_b == '0 && rsp_code_out_c == '0))
      else $error("decode word carries encode fields");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_code_out_a <= SCALE && rsp_code_out_b <= SCALE &&
                     rsp_code_out_c <= SCALE))
      else $error("code beyond scale");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("pipeline not empty after reset");

endmodule
